FILE: rtl/core/apet_pkg.sv
package apet_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CYCLE_W    = 16;
	localparam int LEVEL_W    = 16;
	localparam int QUOT_W     = 17;
	localparam int BIT_IDX_W  = $clog2(QUOT_W);
	localparam int RAW_W      = 19;

	localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_OUTPUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSED         = 3'd4;

	localparam logic [1:0] LOOP_CONST   = 2'd0;
	localparam logic [1:0] LOOP_ONESHOT = 2'd1;
	localparam logic [1:0] LOOP_REPEAT  = 2'd2;
	localparam logic [1:0] LOOP_MIRROR  = 2'd3;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_STEP   = 2'd1;
	localparam logic [1:0] EASE_ZERO   = 2'd2;
	localparam logic [1:0] EASE_ONE    = 2'd3;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [1:0]         LOOP_MODE_RST    = LOOP_ONESHOT;
	localparam logic [1:0]         EASE_MODE_RST    = EASE_LINEAR;
	localparam logic [CYCLE_W-1:0] CYCLE_LENGTH_RST = 16'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                 load_in;
		logic                 calc;
		logic                 prep;
		logic                 div_step;
		logic [BIT_IDX_W-1:0] div_bit;
		logic                 commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic skip;
		logic out_free;
	} ctl_sts_t;

endpackage

FILE: rtl/core/apet_ctrl.sv
module apet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  apet_pkg::ctl_sts_t  sts,
	output apet_pkg::ctl_cmd_t  cmd
);

	apet_pkg::state_t state_q;
	apet_pkg::state_t state_nx;
	logic [apet_pkg::BIT_IDX_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apet_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == apet_pkg::ST_PREP) begin
				cnt_q <= apet_pkg::BIT_IDX_W'(apet_pkg::QUOT_W - 1);
			end else if (state_q == apet_pkg::ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			apet_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = sts.skip ? apet_pkg::ST_FIN : apet_pkg::ST_CALC;
				end
			end
			apet_pkg::ST_CALC: state_nx = apet_pkg::ST_PREP;
			apet_pkg::ST_PREP: state_nx = apet_pkg::ST_DIV;
			apet_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_nx = apet_pkg::ST_FIN;
				end
			end
			apet_pkg::ST_FIN: begin
				if (sts.out_free) begin
					state_nx = apet_pkg::ST_IDLE;
				end
			end
			default: state_nx = apet_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.div_bit  = cnt_q;
		unique case (state_q)
			apet_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			apet_pkg::ST_CALC: cmd.calc = 1'b1;
			apet_pkg::ST_PREP: cmd.prep = 1'b1;
			apet_pkg::ST_DIV:  cmd.div_step = 1'b1;
			apet_pkg::ST_FIN:  cmd.commit = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/apet_dp.sv
module apet_dp #(
	parameter int TIME_WIDTH = apet_pkg::TIME_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  apet_pkg::ctl_cmd_t                cmd,
	output apet_pkg::ctl_sts_t                sts,
	input  logic                              command,
	input  logic [15:0]                       time_delta,
	input  logic [15:0]                       rate_scale,
	input  logic [1:0]                        loop_mode,
	input  logic [1:0]                        ease_mode,
	input  logic [apet_pkg::CYCLE_W-1:0]      cycle_length,
	input  logic                              reverse_output,
	input  logic                              paused,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [apet_pkg::LEVEL_W-1:0]      level,
	output logic [31:0]                       elapsed_out
);

	localparam int XW = (TIME_WIDTH > 33) ? TIME_WIDTH : 33;
	localparam int SW = XW + 1;
	localparam int QW = apet_pkg::QUOT_W;
	localparam int CW = apet_pkg::CYCLE_W;
	localparam int RW = apet_pkg::RAW_W;

	logic                  cmd_q;
	logic [15:0]           dt_q;
	logic [15:0]           rate_q;
	logic [TIME_WIDTH-1:0] t_q;
	logic                  ovf_q;
	logic [CW-1:0]         rem_q;
	logic [QW-1:0]         quot_q;
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [apet_pkg::LEVEL_W-1:0] held_q;
	logic                  out_valid_q;
	logic [apet_pkg::LEVEL_W-1:0] level_q;
	logic [31:0]           elapsed_out_q;

	logic [CW-1:0]         cl_eff;
	logic [31:0]           inc;
	logic [SW-1:0]         sum;
	logic [TIME_WIDTH-1:0] t_sat;
	logic [XW-1:0]         t_x;
	logic [XW-1:0]         c_x;
	logic [XW-1:0]         c2_x;
	logic [XW-1:0]         t_shift;
	logic                  gt_c;
	logic                  gt_2c;
	logic [QW-1:0]         t_low;
	logic [QW-1:0]         cand;
	logic                  ge;
	logic [QW-1:0]         quot_sat;
	logic signed [RW-1:0]  raw_base;
	logic signed [RW-1:0]  raw_loop;
	logic [XW-1:0]         t_new;
	logic [apet_pkg::LEVEL_W-1:0] held_calc;
	logic [TIME_WIDTH-1:0] elapsed_nx;
	logic [apet_pkg::LEVEL_W-1:0] held_nx;
	logic [XW-1:0]         elapsed_nx_x;

	assign cl_eff = (cycle_length == '0) ? CW'(1) : cycle_length;

	assign inc   = dt_q * rate_q;
	assign sum   = SW'(elapsed_q) + SW'(inc);
	assign t_sat = (sum > SW'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	assign t_x     = XW'(t_q);
	assign c_x     = XW'({cl_eff, 15'b0});
	assign c2_x    = XW'({cl_eff, 16'b0});
	assign t_shift = t_x >> QW;
	assign gt_c    = t_x > c_x;
	assign gt_2c   = t_x > c2_x;

	assign t_low = t_q[QW-1:0];
	assign cand  = {rem_q, t_low[cmd.div_bit]};
	assign ge    = cand >= {1'b0, cl_eff};

	assign quot_sat = ovf_q ? {QW{1'b1}} : quot_q;

	always_comb begin
		case (ease_mode)
			apet_pkg::EASE_LINEAR: raw_base = RW'($signed({2'b00, quot_sat}));
			apet_pkg::EASE_STEP:   raw_base = gt_c ? RW'(32768) : RW'(0);
			apet_pkg::EASE_ZERO:   raw_base = RW'(0);
			default:               raw_base = RW'(32768);
		endcase
	end

	always_comb begin
		raw_loop = raw_base;
		t_new    = t_x;
		if (gt_c) begin
			case (loop_mode)
				apet_pkg::LOOP_CONST: ;
				apet_pkg::LOOP_ONESHOT: raw_loop = RW'(32768);
				apet_pkg::LOOP_REPEAT: begin
					raw_loop = raw_base - RW'(32768);
					t_new    = t_x - c_x;
				end
				default: begin
					if (gt_2c) begin
						raw_loop = raw_base - RW'(65536);
						t_new    = t_x - c2_x;
					end else begin
						raw_loop = RW'(65536) - raw_base;
					end
				end
			endcase
		end
	end

	always_comb begin
		if (raw_loop < 0) begin
			held_calc = '0;
		end else if (raw_loop > RW'(32768)) begin
			held_calc = apet_pkg::ONE_Q15;
		end else begin
			held_calc = raw_loop[apet_pkg::LEVEL_W-1:0];
		end
	end

	always_comb begin
		if (cmd_q == apet_pkg::CMD_RESTART) begin
			elapsed_nx = '0;
			held_nx    = held_q;
		end else if (paused) begin
			elapsed_nx = elapsed_q;
			held_nx    = held_q;
		end else begin
			elapsed_nx = t_new[TIME_WIDTH-1:0];
			held_nx    = held_calc;
		end
	end

	assign elapsed_nx_x = XW'(elapsed_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				elapsed_q   <= elapsed_nx;
				held_q      <= held_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= command;
			dt_q   <= time_delta;
			rate_q <= rate_scale;
		end
		if (cmd.calc) begin
			t_q <= t_sat;
		end
		if (cmd.prep) begin
			ovf_q  <= t_x >= XW'({cl_eff, 17'b0});
			rem_q  <= t_shift[CW-1:0];
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? CW'(cand - {1'b0, cl_eff}) : cand[CW-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
		end
		if (cmd.commit) begin
			level_q       <= reverse_output ? apet_pkg::ONE_Q15 - held_nx : held_nx;
			elapsed_out_q <= elapsed_nx_x[31:0];
		end
	end

	assign sts.skip     = (command == apet_pkg::CMD_RESTART) || paused;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign elapsed_out = elapsed_out_q;

endmodule

FILE: rtl/core/animation_phase_easing_timer.sv
// Animation envelope timer. A tick transfer adds time_delta times rate_scale (Q1.15) to a
// saturating Q17.15 elapsed-time accumulator and returns the eased, looped and optionally
// reversed level in Q1.15 together with the new accumulator; a restart transfer clears the
// accumulator and returns the previous level. Every input transfer yields exactly one
// result. A tick passes through the multiply-add, a divider set-up step, the bit-serial
// divider of elapsed time by the cycle length and a finishing step before its result is
// valid; a restart or a paused tick goes straight to the finishing step. The next
// input is taken once the previous item has been handed to the output register, which
// holds one result until out_ready takes it. Configuration writes take effect at once and
// belong only in idle periods.
module animation_phase_easing_timer #(
	parameter int TIME_WIDTH = apet_pkg::TIME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [apet_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apet_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [15:0]                         time_delta,
	input  logic [15:0]                         rate_scale,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [apet_pkg::LEVEL_W-1:0]        level,
	output logic [31:0]                         elapsed_out
);

	logic [1:0]                   loop_mode_q;
	logic [1:0]                   ease_mode_q;
	logic [apet_pkg::CYCLE_W-1:0] cycle_length_q;
	logic                         reverse_output_q;
	logic                         paused_q;

	apet_pkg::ctl_cmd_t ctl_cmd;
	apet_pkg::ctl_sts_t ctl_sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q      <= apet_pkg::LOOP_MODE_RST;
			ease_mode_q      <= apet_pkg::EASE_MODE_RST;
			cycle_length_q   <= apet_pkg::CYCLE_LENGTH_RST;
			reverse_output_q <= 1'b0;
			paused_q         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apet_pkg::REG_LOOP_MODE:      loop_mode_q      <= cfg_data[1:0];
				apet_pkg::REG_EASE_MODE:      ease_mode_q      <= cfg_data[1:0];
				apet_pkg::REG_CYCLE_LENGTH:   cycle_length_q   <= cfg_data[apet_pkg::CYCLE_W-1:0];
				apet_pkg::REG_REVERSE_OUTPUT: reverse_output_q <= cfg_data[0];
				apet_pkg::REG_PAUSED:         paused_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	apet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	apet_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (ctl_sts),
		.command        (command),
		.time_delta     (time_delta),
		.rate_scale     (rate_scale),
		.loop_mode      (loop_mode_q),
		.ease_mode      (ease_mode_q),
		.cycle_length   (cycle_length_q),
		.reverse_output (reverse_output_q),
		.paused         (paused_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level          (level),
		.elapsed_out    (elapsed_out)
	);

endmodule

FILE: tb/animation_phase_easing_timer_checker.sv
module animation_phase_easing_timer_checker
	import apet_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 command,
	input  logic [15:0]          time_delta,
	input  logic [15:0]          rate_scale,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [LEVEL_W-1:0]   level,
	input  logic [31:0]          elapsed_out,
	output int                   mismatch_count,
	output int                   owed_count
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] level;
		logic [31:0] elapsed;
	} timer_result_t;

	timer_result_t owed_results[$];

	logic [1:0]  loop_mode;
	logic [1:0]  ease_mode;
	logic [15:0] cycle_length;
	logic        reverse_output;
	logic        paused;

	logic [31:0] elapsed_time;
	logic [16:0] held_level;
	int          errors;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic advance_envelope(input logic cmd, input logic [15:0] dt,
			input logic [15:0] rate);
		longint unsigned inc;
		longint unsigned t;
		longint unsigned c;
		longint          raw;
		longint          one;
		logic [16:0]     shown;
		timer_result_t   r;
		one = longint'(ONE_Q15);
		if (cmd == CMD_RESTART) begin
			elapsed_time = '0;
		end else if (!paused) begin
			inc = {48'd0, dt} * {48'd0, rate};
			t = {32'd0, elapsed_time} + inc;
			if (t > 64'hFFFF_FFFF) begin
				t = 64'hFFFF_FFFF;
			end
			c = ((cycle_length == '0) ? 64'd1 : {48'd0, cycle_length}) << 15;
			case (ease_mode)
				EASE_LINEAR: raw = longint'((t << 15) / c);
				EASE_STEP:   raw = (t > c) ? one : 0;
				EASE_ZERO:   raw = 0;
				default:     raw = one;
			endcase
			if (t > c) begin
				case (loop_mode)
					LOOP_CONST: ;
					LOOP_ONESHOT: raw = one;
					LOOP_REPEAT: begin
						t -= c;
						raw -= one;
					end
					default: begin
						if (t > 2 * c) begin
							t -= 2 * c;
							raw -= 2 * one;
						end else begin
							raw = 2 * one - raw;
						end
					end
				endcase
			end
			if (raw < 0) begin
				raw = 0;
			end
			if (raw > one) begin
				raw = one;
			end
			elapsed_time = t[31:0];
			held_level = raw[16:0];
		end
		shown = reverse_output ? (17'd32768 - held_level) : held_level;
		r.level = shown[15:0];
		r.elapsed = elapsed_time;
		owed_results.push_back(r);
	endtask

	task automatic check_result();
		timer_result_t want;
		if (owed_results.size() == 0) begin
			report_mismatch("result with no transfer waiting", level, 0);
		end else begin
			want = owed_results.pop_front();
			if (level !== want.level) begin
				report_mismatch("level", level, want.level);
			end
			if (elapsed_out !== want.elapsed) begin
				report_mismatch("elapsed_out", elapsed_out, want.elapsed);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode = LOOP_MODE_RST;
			ease_mode = EASE_MODE_RST;
			cycle_length = CYCLE_LENGTH_RST;
			reverse_output = 1'b0;
			paused = 1'b0;
			elapsed_time = '0;
			held_level = '0;
			errors = 0;
			owed_results.delete();
			owed_count <= 0;
			mismatch_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				advance_envelope(command, time_delta, rate_scale);
			end
			if (out_valid && out_ready) begin
				check_result();
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LOOP_MODE:      loop_mode = cfg_data[1:0];
					REG_EASE_MODE:      ease_mode = cfg_data[1:0];
					REG_CYCLE_LENGTH:   cycle_length = cfg_data[15:0];
					REG_REVERSE_OUTPUT: reverse_output = cfg_data[0];
					REG_PAUSED:         paused = cfg_data[0];
					default: ;
				endcase
			end
			owed_count <= owed_results.size();
			mismatch_count <= errors;
		end
	end

endmodule

FILE: tb/animation_phase_easing_timer_tb.sv
module animation_phase_easing_timer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import apet_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  command;
	logic [15:0]           time_delta;
	logic [15:0]           rate_scale;
	logic                  out_valid;
	logic                  out_ready;
	logic [LEVEL_W-1:0]    level;
	logic [31:0]           elapsed_out;

	int          fails;
	int          owed;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_requests;
	int          holds_done;
	int          quiet = 0;
	logic [15:0] cur_cycle;

	animation_phase_easing_timer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.time_delta (time_delta),
		.rate_scale (rate_scale),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.level      (level),
		.elapsed_out(elapsed_out)
	);

	animation_phase_easing_timer_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.time_delta    (time_delta),
		.rate_scale    (rate_scale),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level         (level),
		.elapsed_out   (elapsed_out),
		.mismatch_count(fails),
		.owed_count    (owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		out_ready <= 1'b0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [15:0] dt, input logic [15:0] rate);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		time_delta <= dt;
		rate_scale <= rate;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_tick();
		logic        cmd;
		logic [15:0] dt;
		logic [15:0] rate;
		int          span;
		int          r;
		cmd = ($urandom_range(0, 9) == 0) ? CMD_RESTART : CMD_TICK;
		span = 3 * int'(cur_cycle) + 3;
		if (span > 65535) begin
			span = 65535;
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			dt = 16'hFFFF;
		end else if (r == 1) begin
			dt = 16'd0;
		end else if (r < 4) begin
			dt = 16'($urandom());
		end else begin
			dt = 16'($urandom_range(0, span));
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			rate = 16'd32768;
		end else if (r == 1) begin
			rate = 16'hFFFF;
		end else if (r == 2) begin
			rate = 16'd0;
		end else if (r < 5) begin
			rate = 16'($urandom());
		end else begin
			rate = 16'($urandom_range(16384, 40000));
		end
		send_item(cmd, dt, rate);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] loop_sel, input logic [1:0] ease_sel,
			input logic [15:0] cyc, input logic rev, input logic hold_time);
		drain();
		write_reg(REG_LOOP_MODE, {14'd0, loop_sel});
		write_reg(REG_EASE_MODE, {14'd0, ease_sel});
		write_reg(REG_CYCLE_LENGTH, cyc);
		write_reg(REG_REVERSE_OUTPUT, {15'd0, rev});
		write_reg(REG_PAUSED, {15'd0, hold_time});
		cfg_we <= 1'b0;
		cur_cycle = cyc;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0]  ease_pick;
		logic [15:0] cyc_pick;
		int          r;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		time_delta <= '0;
		rate_scale <= '0;
		tx_idle_pct = 19;
		rx_idle_pct = 70;
		hold_requests = 0;
		cur_cycle = CYCLE_LENGTH_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(LOOP_ONESHOT, EASE_LINEAR, 16'd1000, 1'b0, 1'b0);
		send_item(CMD_TICK, 16'd0, 16'd0);
		send_item(CMD_TICK, 16'd1000, 16'd16384);
		send_item(CMD_TICK, 16'hFFFF, 16'd32768);
		send_item(CMD_RESTART, 16'hFFFF, 16'hFFFF);

		// Three full-scale ticks push the accumulator into saturation.
		set_config(LOOP_CONST, EASE_LINEAR, 16'hFFFF, 1'b0, 1'b0);
		send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
		send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
		send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
		send_item(CMD_RESTART, 16'd0, 16'd0);

		set_config(LOOP_REPEAT, EASE_STEP, 16'd0, 1'b0, 1'b0);
		send_item(CMD_TICK, 16'd1, 16'd32768);
		send_item(CMD_TICK, 16'd3, 16'd49152);
		send_item(CMD_TICK, 16'd1, 16'd65535);

		set_config(LOOP_MIRROR, EASE_LINEAR, 16'd10, 1'b1, 1'b0);
		send_item(CMD_TICK, 16'd15, 16'd32768);
		send_item(CMD_TICK, 16'd10, 16'd32768);
		send_item(CMD_TICK, 16'd40, 16'd32768);

		set_config(LOOP_REPEAT, EASE_ZERO, 16'd10, 1'b0, 1'b1);
		send_item(CMD_TICK, 16'd100, 16'd100);
		send_item(CMD_RESTART, 16'd5, 16'd5);
		send_item(CMD_TICK, 16'd7, 16'd32768);

		set_config(LOOP_CONST, EASE_ONE, 16'd1, 1'b1, 1'b0);
		send_item(CMD_TICK, 16'd0, 16'd0);
		send_item(CMD_TICK, 16'd2, 16'd32768);

		for (int p = 0; p < 16; p++) begin
			if (p < 5) begin
				tx_idle_pct = 19;
				rx_idle_pct = 70;
			end else if (p < 10) begin
				tx_idle_pct = 70;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			r = $urandom_range(0, 7);
			ease_pick = (r < 4) ? EASE_LINEAR : 2'($urandom_range(0, 3));
			r = $urandom_range(0, 9);
			if (r == 0) begin
				cyc_pick = 16'd0;
			end else if (r == 1) begin
				cyc_pick = 16'hFFFF;
			end else if (r == 2) begin
				cyc_pick = 16'd1;
			end else if (r == 3) begin
				cyc_pick = 16'($urandom());
			end else begin
				cyc_pick = 16'($urandom_range(1, 64));
			end
			set_config(2'($urandom_range(0, 3)), ease_pick, cyc_pick,
				1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
			if (p == 1) begin
				hold_requests++;
			end
			repeat (33) send_random_tick();
		end

		drain();
		repeat (30) @(posedge clk);
		if (fails == 0 && owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
